// ===== design/assert_macros.svh =====
// Assertion macros used by the notifier design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked on every clock, off during reset.
`define LCHN_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Condition that must never hold outside reset.
`define LCHN_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define LCHN_ASSERT_IMPL(label, cond, prop, msg)
`define LCHN_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== design/lchn_pkg.sv =====
// Package: codes, widths and reset values of the link change hold-off notifier.
package lchn_pkg;

    localparam int CmdW   = 2;
    localparam int TypeW  = 3;
    localparam int KindW  = 2;
    localparam int DelayW = 16;
    localparam int CfgIdxW = 3;

    typedef logic [TypeW-1:0]  link_type_t;
    typedef logic [DelayW-1:0] delay_t;

    // Commands
    localparam logic [CmdW-1:0] CMD_TICK = 2'd0;
    localparam logic [CmdW-1:0] CMD_ADDR = 2'd1;
    localparam logic [CmdW-1:0] CMD_KIND = 2'd2;

    // Report kinds
    localparam logic [KindW-1:0] REPORT_DOWN   = 2'd0;
    localparam logic [KindW-1:0] REPORT_UP     = 2'd1;
    localparam logic [KindW-1:0] REPORT_CHANGE = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_INITIAL_TYPE  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ADDR_OFFLINE  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ADDR_ONLINE   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KIND_OFFLINE  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_KIND_ONLINE   = 3'd4;

    // Link type that means no connection
    localparam link_type_t TYPE_NONE   = 3'd0;
    localparam delay_t     DELAY_RESET = 16'd1000;

endpackage

// ===== design/link_change_holdoff_notifier.sv =====
// Link change hold-off notifier: accepts ticks and link events, reports the
// settled link type once the hold-off countdown runs out.
//
// Takes one item per clock unless the input register holds back. An input
// transfer lands in an input register; a single pass of logic on the
// registered item updates the pending type, the countdown and the announced
// type and loads the result register, from which the result is transferred.
// The input register holds back only when its item would produce a result
// while the result register is full and not being taken; ticks that expire
// nothing and events keep flowing.
// Configuration writes take effect at the edge of the write enable.
`include "assert_macros.svh"

module link_change_holdoff_notifier (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lchn_pkg::CmdW-1:0]           command,
    input  logic [lchn_pkg::TypeW-1:0]          link_type,
    // Result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lchn_pkg::KindW-1:0]          report_kind,
    output logic [lchn_pkg::TypeW-1:0]          announced_type,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [lchn_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [lchn_pkg::DelayW-1:0]         cfg_data
);

    // Configuration registers
    lchn_pkg::delay_t     addr_off_reg, addr_on_reg, kind_off_reg, kind_on_reg;

    // Input register
    logic                        in_valid_reg;
    logic [lchn_pkg::CmdW-1:0]   cmd_reg;
    lchn_pkg::link_type_t        type_reg;

    // Block state
    lchn_pkg::link_type_t pend_reg, pend_next;
    lchn_pkg::link_type_t ann_reg, ann_next;
    logic                 has_reg, has_next;
    logic                 active_reg, active_next;
    lchn_pkg::delay_t     cnt_reg, cnt_next;

    // Result register
    logic                          out_valid_reg;
    logic [lchn_pkg::KindW-1:0]    kind_reg, kind_next;
    lchn_pkg::link_type_t          out_type_reg;

    logic             offline;
    logic             produce;
    logic             fire;
    lchn_pkg::delay_t delay_sel;
    lchn_pkg::delay_t cnt_dec;

    // Update logic for the item in the input register
    always_comb
    begin
        offline     = (ann_reg == lchn_pkg::TYPE_NONE);
        pend_next   = pend_reg;
        ann_next    = ann_reg;
        has_next    = has_reg;
        active_next = active_reg;
        cnt_next    = cnt_reg;
        kind_next   = lchn_pkg::REPORT_CHANGE;
        produce     = 1'b0;
        delay_sel   = '0;
        cnt_dec     = cnt_reg - lchn_pkg::delay_t'(1);
        case (cmd_reg)
            lchn_pkg::CMD_ADDR, lchn_pkg::CMD_KIND:
            begin
                if (cmd_reg == lchn_pkg::CMD_ADDR)
                    delay_sel = offline ? addr_off_reg : addr_on_reg;
                else
                    delay_sel = offline ? kind_off_reg : kind_on_reg;
                pend_next   = type_reg;
                active_next = 1'b1;
                // zero delay counts as one tick
                cnt_next    = (delay_sel == '0) ? lchn_pkg::delay_t'(1) : delay_sel;
            end
            lchn_pkg::CMD_TICK:
            begin
                if (active_reg)
                begin
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        active_next = 1'b0;
                        // repeat of none after an earlier report is dropped
                        if (!(has_reg && offline && pend_reg == lchn_pkg::TYPE_NONE))
                        begin
                            produce  = 1'b1;
                            has_next = 1'b1;
                            ann_next = pend_reg;
                            if (pend_reg == lchn_pkg::TYPE_NONE && !offline)
                                kind_next = lchn_pkg::REPORT_DOWN;
                            else if (pend_reg != lchn_pkg::TYPE_NONE && offline)
                                kind_next = lchn_pkg::REPORT_UP;
                            else
                                kind_next = lchn_pkg::REPORT_CHANGE;
                        end
                    end
                end
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    // Flow control: hold the input register only if its result has no room
    assign fire     = in_valid_reg && (!produce || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg  <= command;
            type_reg <= link_type;
        end
    end

    // State and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= lchn_pkg::TYPE_NONE;
            ann_reg      <= lchn_pkg::TYPE_NONE;
            has_reg      <= 1'b0;
            active_reg   <= 1'b0;
            cnt_reg      <= '0;
            addr_off_reg <= lchn_pkg::DELAY_RESET;
            addr_on_reg  <= lchn_pkg::DELAY_RESET;
            kind_off_reg <= lchn_pkg::DELAY_RESET;
            kind_on_reg  <= lchn_pkg::DELAY_RESET;
        end
        else
        begin
            if (fire)
            begin
                pend_reg   <= pend_next;
                ann_reg    <= ann_next;
                has_reg    <= has_next;
                active_reg <= active_next;
                cnt_reg    <= cnt_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    lchn_pkg::CFG_INITIAL_TYPE: ann_reg      <= cfg_data[lchn_pkg::TypeW-1:0];
                    lchn_pkg::CFG_ADDR_OFFLINE: addr_off_reg <= cfg_data;
                    lchn_pkg::CFG_ADDR_ONLINE:  addr_on_reg  <= cfg_data;
                    lchn_pkg::CFG_KIND_OFFLINE: kind_off_reg <= cfg_data;
                    lchn_pkg::CFG_KIND_ONLINE:  kind_on_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && produce)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            kind_reg     <= kind_next;
            out_type_reg <= pend_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign report_kind    = kind_reg;
    assign announced_type = out_type_reg;

    // Checks
    `LCHN_ASSERT_IMPL(a_cnt_live, active_reg, cnt_reg != '0, "active countdown at zero")
    `LCHN_ASSERT_NEVER(a_up_none, out_valid_reg && kind_reg == lchn_pkg::REPORT_UP && out_type_reg == lchn_pkg::TYPE_NONE, "up reported with no connection")
    `LCHN_ASSERT_NEVER(a_down_type, out_valid_reg && kind_reg == lchn_pkg::REPORT_DOWN && out_type_reg != lchn_pkg::TYPE_NONE, "down reported with a link type")
    `LCHN_ASSERT_IMPL(a_first_rpt, $rose(has_reg), out_valid_reg, "first report lost")

endmodule
